>>> sv/slim_pkg.sv
package slim_pkg;

  localparam int VALUE_W = 31;
  localparam int CMD_W   = 2;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [CMD_W-1:0]   cmd_t;

  localparam cmd_t CMD_APPEND_A = 2'd0;
  localparam cmd_t CMD_APPEND_B = 2'd1;
  localparam cmd_t CMD_RUN      = 2'd2;
  localparam cmd_t CMD_NONE     = 2'd3;

  localparam logic MODE_INTERSECT = 1'b0;
  localparam logic MODE_MERGE     = 1'b1;

endpackage

>>> sv/slim_if.sv
interface slim_cmd_if;
  logic             valid;
  logic             ready;
  slim_pkg::cmd_t   command;
  slim_pkg::value_t item_value;

  modport source (output valid, command, item_value, input ready);
  modport sink   (input valid, command, item_value, output ready);
endinterface

interface slim_res_if;
  logic             valid;
  logic             ready;
  slim_pkg::value_t result_value;
  logic             last_result;
  logic             empty_result;
  logic             overflow_seen;

  modport source (output valid, result_value, last_result, empty_result, overflow_seen,
                  input ready);
  modport sink   (input valid, result_value, last_result, empty_result, overflow_seen,
                  output ready);
endinterface

interface slim_cfg_if;
  logic valid;
  logic ready;
  logic set_mode;

  modport source (output valid, set_mode, input ready);
  modport sink   (input valid, set_mode, output ready);
endinterface

>>> sv/slim_ram.sv
module slim_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sorted_list_intersect_merge_top.sv
// append items are accepted back to back, one per cycle, while no run is in progress (idle)
// a run walks the lists in steps, each a ram read (fetch) then a compare, and then closes;
// a compare that must push out a held hit, and the close, stall while the result side is busy
// a found result is held and leaves when the next one is found, the last one at close
// synchronous active-high reset clears counts, overflow flag, mode and control;
// list memories are not cleared, only entries below the counts are ever used
module sorted_list_intersect_merge_top #(
  parameter int LIST_DEPTH = 32
) (
  input logic       clk,
  input logic       rst,
  slim_cmd_if.sink  item_in,
  slim_res_if.source result_out,
  slim_cfg_if.sink  cfg
);
  import slim_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_COMPARE, S_FINISH} state_t;

  state_t        state;
  logic          set_mode;
  logic [CW-1:0] count_a, count_b;
  logic [CW-1:0] ptr_a, ptr_b;
  logic          overflow_flag;
  value_t        held_value;
  logic          held_valid;
  value_t        rd_a, rd_b;

  logic    in_fire, append_a, append_b;
  logic    out_free;
  logic    res_load;
  logic    a_left, b_left, walk_done;
  logic    emit, adv_a, adv_b;
  value_t  emit_value;

  assign cfg.ready     = 1'b1;
  assign item_in.ready = (state == S_IDLE);
  assign in_fire       = item_in.valid && item_in.ready;
  assign append_a      = in_fire && (item_in.command == CMD_APPEND_A) && (count_a < FULL);
  assign append_b      = in_fire && (item_in.command == CMD_APPEND_B) && (count_b < FULL);
  assign out_free      = !result_out.valid || result_out.ready;
  // result register loads on a pushed-out hit or at run close
  assign res_load      = ((state == S_COMPARE) && emit && held_valid && out_free) ||
                         ((state == S_FINISH) && out_free);

  slim_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (append_a),
    .waddr (count_a[AW-1:0]),
    .wdata (item_in.item_value),
    .raddr (ptr_a[AW-1:0]),
    .rdata (rd_a)
  );

  slim_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (append_b),
    .waddr (count_b[AW-1:0]),
    .wdata (item_in.item_value),
    .raddr (ptr_b[AW-1:0]),
    .rdata (rd_b)
  );

  assign a_left    = ptr_a < count_a;
  assign b_left    = ptr_b < count_b;
  assign walk_done = (set_mode == MODE_MERGE) ? (!a_left && !b_left) : (!a_left || !b_left);

  always_comb begin
    emit       = 1'b0;
    adv_a      = 1'b0;
    adv_b      = 1'b0;
    emit_value = rd_a;
    if (set_mode == MODE_MERGE) begin
      emit = 1'b1;
      if (!a_left) begin
        adv_b = 1'b1;
      end else if (!b_left) begin
        adv_a = 1'b1;
      end else begin
        adv_a = (rd_a <= rd_b);
        adv_b = !adv_a;
      end
      emit_value = adv_a ? rd_a : rd_b;
    end else begin
      if (rd_a > rd_b) begin
        adv_b = 1'b1;
      end else begin
        adv_a = 1'b1;
        emit  = (rd_a == rd_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      set_mode         <= 1'b0;
      count_a          <= '0;
      count_b          <= '0;
      ptr_a            <= '0;
      ptr_b            <= '0;
      overflow_flag    <= 1'b0;
      held_valid       <= 1'b0;
      result_out.valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        set_mode <= cfg.set_mode;
      end
      if (res_load) begin
        result_out.valid <= 1'b1;
      end else if (result_out.ready) begin
        result_out.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (item_in.command)
              CMD_APPEND_A: begin
                if (append_a) count_a <= count_a + 1'b1;
                else          overflow_flag <= 1'b1;
              end
              CMD_APPEND_B: begin
                if (append_b) count_b <= count_b + 1'b1;
                else          overflow_flag <= 1'b1;
              end
              CMD_RUN: begin
                ptr_a <= '0;
                ptr_b <= '0;
                state <= S_FETCH;
              end
              default: ;
            endcase
          end
        end
        S_FETCH: begin
          state <= walk_done ? S_FINISH : S_COMPARE;
        end
        S_COMPARE: begin
          // a new hit pushes the held one out, so stall if the output is busy
          if (!(emit && held_valid && !out_free)) begin
            if (emit) begin
              if (held_valid) begin
                result_out.result_value  <= held_value;
                result_out.last_result   <= 1'b0;
                result_out.empty_result  <= 1'b0;
                result_out.overflow_seen <= overflow_flag;
              end
              held_value <= emit_value;
              held_valid <= 1'b1;
            end
            if (adv_a) ptr_a <= ptr_a + 1'b1;
            if (adv_b) ptr_b <= ptr_b + 1'b1;
            state <= S_FETCH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            result_out.result_value  <= held_valid ? held_value : '0;
            result_out.last_result   <= 1'b1;
            result_out.empty_result  <= !held_valid;
            result_out.overflow_seen <= overflow_flag;
            held_valid    <= 1'b0;
            count_a       <= '0;
            count_b       <= '0;
            overflow_flag <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count_a <= FULL) && (count_b <= FULL))
    else $error("list count beyond depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMPARE) |-> ((ptr_a <= count_a) && (ptr_b <= count_b)))
    else $error("walk pointer beyond list count");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> (count_a == '0 && count_b == '0 && !overflow_flag
                                         && !held_valid && result_out.last_result))
    else $error("run close did not clear lists");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.empty_result) |-> result_out.last_result)
    else $error("empty result not marked last");

  a_idle_nothing_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !held_valid)
    else $error("result held while idle");

endmodule
